// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C master transaction engine.
package i2cm_pkg;

	localparam int FifoDepth = 4;
	localparam int FifoAw = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
	localparam int FillW = $clog2(FifoDepth + 1);
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_PUSH = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [1:0] KIND_PROBE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0, PH_ST_A = 5'd1, PH_ST_B = 5'd2, PH_ST_C = 5'd3,
		PH_TX_PRE = 5'd4, PH_TX_LO1 = 5'd5, PH_TX_LO2 = 5'd6, PH_TX_HI = 5'd7,
		PH_AK_LO = 5'd8, PH_AK_HI = 5'd9, PH_AK_POLL = 5'd10, PH_AK_END = 5'd11,
		PH_RX_PRE = 5'd12, PH_RX_LO = 5'd13, PH_RX_HI = 5'd14, PH_RX_HI2 = 5'd15,
		PH_MA_LO = 5'd16, PH_MA_HI = 5'd17, PH_SP_A = 5'd18, PH_SP_B = 5'd19,
		PH_SP_C = 5'd20, PH_WAIT = 5'd21
	} phase_t;

	typedef enum logic [2:0] {
		SG_DEV = 3'd0, SG_AHI = 3'd1, SG_ALO = 3'd2,
		SG_DEVR = 3'd3, SG_DATA = 3'd4, SG_RECV = 3'd5
	} stage_t;

	// Decoded input transaction handed from the front end to the sequencer
	typedef struct packed {
		cmd_t cmd;
		logic [1:0] kind;
		logic [7:0] device_byte;
		logic [15:0] data_address;
		logic wide_address;
		logic word_mode;
		logic [15:0] count;
		logic [15:0] write_data;
		logic sda_in;
	} item_t;

	// Phase durations in ticks
	function automatic logic [4:0] phase_len(input phase_t ph);
		case (ph)
			PH_ST_A, PH_TX_LO1, PH_TX_LO2, PH_AK_LO, PH_AK_END, PH_RX_LO,
			PH_RX_HI2, PH_MA_LO, PH_SP_A: phase_len = 5'd5;
			PH_ST_B, PH_ST_C, PH_TX_PRE, PH_AK_HI, PH_RX_PRE, PH_RX_HI,
			PH_SP_B, PH_SP_C: phase_len = 5'd10;
			PH_TX_HI, PH_MA_HI: phase_len = 5'd20;
			default: phase_len = 5'd0;
		endcase
	endfunction

endpackage

// ===== design/i2c_master_transaction_engine_core.sv =====
// Top level of the I2C master transaction engine.
// One input transaction is taken every clock cycle while a queue of two entries has room;
// the queue decouples the input from the bus sequencer, which handles one tick, begin or
// push per cycle unless a waiting result stalls it, and registers one result for each;
// the queue takes inputs while a result waits. Bus timing is counted in ticks, not clocks.
module i2c_master_transaction_engine_core import i2cm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// cmd, kind, device_byte, data_address, wide_address, word_mode, count,
	// write_data, sda_in, from bit 0 up (63 bits, zero padded)
	input logic [63:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// scl_level, sda_drive, sda_level, busy_res, read_valid, read_data, read_last,
	// ack_ok, data_wanted, done_res, from bit 0 up (25 bits, zero padded)
	output logic [31:0] m_tdata
);

	logic [15:0] limit_q;
	item_t s_item, q_item;
	logic q_valid, q_ready;

	// Poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 16'd100;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	assign s_item.cmd = cmd_t'(s_tdata[1:0]);
	assign s_item.kind = s_tdata[3:2];
	assign s_item.device_byte = s_tdata[11:4];
	assign s_item.data_address = s_tdata[27:12];
	assign s_item.wide_address = s_tdata[28];
	assign s_item.word_mode = s_tdata[29];
	assign s_item.count = s_tdata[45:30];
	assign s_item.write_data = s_tdata[61:46];
	assign s_item.sda_in = s_tdata[62];

	i2cm_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	i2cm_back u_back (
		.clk(clk), .arst_n(arst_n), .ack_poll_limit(limit_q), .q_valid(q_valid),
		.q_ready(q_ready), .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ===== design/i2cm_front.sv =====
// Input front end: registers transactions into a short queue.
module i2cm_front import i2cm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input item_t s_item,
	output logic q_valid,
	input logic q_ready,
	output item_t q_item
);

	localparam int Aw = $clog2(QDepth);

	item_t buf_q [QDepth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;
	logic push, pop;

	assign s_tready = (cnt_q != QDepth[Aw:0]);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = buf_q[rd_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= s_item;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDepth[Aw:0]) else $error("queue overflow");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QDepth[Aw:0]) |-> !push) else $error("push into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
`endif

endmodule

// ===== design/i2cm_back.sv =====
// Bus sequencer: handles one queue entry at a time and registers a result for each entry.
module i2cm_back import i2cm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [15:0] ack_poll_limit,
	input logic q_valid,
	output logic q_ready,
	input item_t q_item,
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata
);

	phase_t ph_q, ph_n;
	stage_t sg_q, sg_n;
	logic [4:0] dly_q, dly_n;
	logic [15:0] awc_q, awc_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] sh_q, sh_n;
	logic [15:0] rem_q, rem_n;
	logic [7:0] dev_q, dev_n;
	logic [15:0] adr_q, adr_n;
	logic [3:0] flg_q, flg_n;
	logic hh_q, hh_n;
	logic [15:0] wa_q, wa_n;
	logic ack_q, ack_n;
	logic [15:0] fifo_q [FifoDepth];
	logic [FillW-1:0] fill_q, fill_n;
	logic scl_q, scl_n, drv_q, drv_n, lvl_q, lvl_n;
	logic pv, pl, pd;
	logic [15:0] pdat;
	logic fpop, fpush;
	logic [15:0] limit;
	logic [4:0] d1;
	logic [7:0] rb;
	logic adv;

	assign q_ready = !m_tvalid || m_tready;
	assign adv = q_valid && q_ready;
	assign limit = (ack_poll_limit == '0) ? 16'd1 : ack_poll_limit;

	// Next-state sequencing, one queued transaction per cycle while the result register is free or being taken
	always_comb begin
		phase_t tgt;
		logic go, sendb;
		logic [7:0] sb;
		ph_n = ph_q; sg_n = sg_q; dly_n = dly_q; awc_n = awc_q; bit_n = bit_q;
		sh_n = sh_q; rem_n = rem_q; dev_n = dev_q; adr_n = adr_q; flg_n = flg_q;
		hh_n = hh_q; wa_n = wa_q; ack_n = ack_q; fill_n = fill_q;
		scl_n = scl_q; drv_n = drv_q; lvl_n = lvl_q;
		pv = 1'b0; pl = 1'b0; pd = 1'b0; pdat = '0; fpop = 1'b0; fpush = 1'b0;
		tgt = PH_IDLE; go = 1'b0; sendb = 1'b0; sb = '0;
		d1 = dly_q + 5'd1;
		rb = sh_q;
		if (adv) begin
			case (q_item.cmd)
				CMD_TICK: begin
					if (ph_q == PH_AK_POLL) begin
						if (!q_item.sda_in) begin
							ack_n = 1'b1; tgt = PH_AK_END; go = 1'b1;
						end else begin
							awc_n = awc_q + 16'd1;
							if (awc_n >= limit) begin
								ack_n = 1'b0; tgt = PH_AK_END; go = 1'b1;
							end
						end
					end else if (ph_q == PH_WAIT) begin
						if (fill_q != '0) begin
							fpop = 1'b1; wa_n = fifo_q[0]; hh_n = 1'b0;
							sendb = 1'b1; sb = fifo_q[0][7:0];
						end
					end else if (ph_q != PH_IDLE) begin
						if (ph_q == PH_RX_HI && d1 >= phase_len(ph_q))
							sh_n[3'd7 - bit_q[2:0]] = q_item.sda_in;
						rb = sh_n;
						dly_n = d1;
						if (d1 >= phase_len(ph_q)) begin
							go = 1'b1;
							case (ph_q)
								PH_ST_A: tgt = PH_ST_B;
								PH_ST_B: tgt = PH_ST_C;
								PH_ST_C: begin
									sendb = 1'b1;
									sb = (sg_q == SG_DEVR) ? dev_q + 8'd1 : dev_q;
								end
								PH_TX_PRE: tgt = PH_TX_LO1;
								PH_TX_LO1: tgt = PH_TX_LO2;
								PH_TX_LO2: tgt = PH_TX_HI;
								PH_TX_HI: begin
									bit_n = bit_q + 4'd1;
									tgt = (bit_n >= 4'd8) ? PH_AK_LO : PH_TX_LO1;
								end
								PH_AK_LO: tgt = PH_AK_HI;
								PH_AK_HI: tgt = PH_AK_POLL;
								PH_AK_END: begin
									case (sg_q)
										SG_DEV: begin
											if (flg_q[1:0] == KIND_PROBE) tgt = PH_SP_A;
											else if (flg_q[2]) begin
												sg_n = SG_AHI; sendb = 1'b1; sb = adr_q[15:8];
											end else begin
												sg_n = SG_ALO; sendb = 1'b1; sb = adr_q[7:0];
											end
										end
										SG_AHI: begin
											sg_n = SG_ALO; sendb = 1'b1; sb = adr_q[7:0];
										end
										SG_ALO: begin
											if (flg_q[1:0] == KIND_READ) begin
												sg_n = SG_DEVR; tgt = PH_ST_A;
											end else begin
												sg_n = SG_DATA; tgt = PH_WAIT;
												if (fill_q != '0) begin
													fpop = 1'b1; wa_n = fifo_q[0]; hh_n = 1'b0;
													sendb = 1'b1; sb = fifo_q[0][7:0];
												end
											end
										end
										SG_DEVR: begin
											sg_n = SG_RECV; hh_n = 1'b0; bit_n = '0;
											tgt = PH_RX_PRE;
										end
										default: begin
											if (flg_q[3] && !hh_q) begin
												hh_n = 1'b1; sendb = 1'b1; sb = wa_q[15:8];
											end else begin
												rem_n = rem_q - 16'd1;
												if (rem_n == '0) tgt = PH_SP_A;
												else begin
													tgt = PH_WAIT;
													if (fill_q != '0) begin
														fpop = 1'b1; wa_n = fifo_q[0];
														hh_n = 1'b0; sendb = 1'b1;
														sb = fifo_q[0][7:0];
													end
												end
											end
										end
									endcase
								end
								PH_RX_PRE: tgt = PH_RX_LO;
								PH_RX_LO: tgt = PH_RX_HI;
								PH_RX_HI: tgt = PH_RX_HI2;
								PH_RX_HI2: begin
									bit_n = bit_q + 4'd1;
									tgt = (bit_n >= 4'd8) ? PH_MA_LO : PH_RX_LO;
								end
								PH_MA_LO: tgt = PH_MA_HI;
								PH_MA_HI: begin
									tgt = PH_RX_PRE;
									bit_n = '0;
									if (flg_q[3] && !hh_q) begin
										wa_n = {8'd0, rb}; hh_n = 1'b1;
									end else begin
										pv = 1'b1;
										pdat = flg_q[3] ? {rb, wa_q[7:0]} : {8'd0, rb};
										pl = (rem_q == 16'd1);
										hh_n = 1'b0;
										rem_n = rem_q - 16'd1;
										if (rem_n == '0) begin
											tgt = PH_SP_A; bit_n = bit_q;
										end
									end
								end
								PH_SP_A: tgt = PH_SP_B;
								PH_SP_B: tgt = PH_SP_C;
								default: begin
									tgt = PH_IDLE; pd = 1'b1;
								end
							endcase
						end
					end
				end
				CMD_BEGIN: begin
					if (ph_q == PH_IDLE && q_item.kind != KIND_BAD) begin
						if (q_item.kind != KIND_PROBE && q_item.count == '0) pd = 1'b1;
						else begin
							dev_n = q_item.device_byte;
							adr_n = q_item.data_address;
							flg_n = {q_item.word_mode, q_item.wide_address, q_item.kind};
							rem_n = q_item.count;
							hh_n = 1'b0; sg_n = SG_DEV;
							tgt = PH_ST_A; go = 1'b1;
						end
					end
				end
				CMD_PUSH: fpush = (fill_q != FifoDepth[FillW-1:0]);
				default: ;
			endcase
			if (sendb) begin
				sh_n = sb; bit_n = '0; tgt = PH_TX_PRE; go = 1'b1;
			end
			if (fpop) fill_n = fill_n - 1'b1;
			if (fpush) fill_n = fill_n + 1'b1;
			// Phase entry actions on the line registers and the ack poll counter
			if (go) begin
				ph_n = tgt; dly_n = '0;
				case (tgt)
					PH_ST_A: begin scl_n = 1'b0; drv_n = 1'b1; lvl_n = 1'b1; end
					PH_ST_B, PH_TX_HI, PH_RX_HI, PH_MA_HI, PH_SP_B: scl_n = 1'b1;
					PH_ST_C: begin drv_n = 1'b1; lvl_n = 1'b0; end
					PH_TX_PRE, PH_TX_LO1, PH_AK_LO, PH_RX_PRE, PH_WAIT: scl_n = 1'b0;
					PH_TX_LO2: begin drv_n = 1'b1; lvl_n = sh_n[3'd7 - bit_n[2:0]]; end
					PH_AK_HI: begin scl_n = 1'b1; drv_n = 1'b0; end
					PH_AK_POLL: awc_n = '0;
					PH_RX_LO: begin scl_n = 1'b0; drv_n = 1'b0; end
					PH_MA_LO: begin
						scl_n = 1'b0; drv_n = 1'b1;
						lvl_n = (rem_q == 16'd1) && (!flg_q[3] || hh_q);
					end
					PH_SP_A: begin scl_n = 1'b0; drv_n = 1'b1; lvl_n = 1'b0; end
					PH_SP_C: lvl_n = 1'b1;
					PH_IDLE: begin scl_n = 1'b1; drv_n = 1'b1; lvl_n = 1'b1; end
					default: ;
				endcase
			end
		end
	end

	// Write data FIFO, shift-out at the head
	always_ff @(posedge clk) begin
		for (int i = 0; i < FifoDepth; i++) begin
			if (fpop) begin
				if (i < FifoDepth - 1) fifo_q[i] <= fifo_q[i+1];
			end
			if (fpush && FillW'(i) == fill_q - {{(FillW-1){1'b0}}, fpop})
				fifo_q[i] <= q_item.write_data;
		end
	end

	// Sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; sg_q <= SG_DEV; dly_q <= '0; awc_q <= '0; bit_q <= '0;
			sh_q <= '0; rem_q <= '0; dev_q <= '0; adr_q <= '0; flg_q <= '0;
			hh_q <= 1'b0; wa_q <= '0; ack_q <= 1'b0; fill_q <= '0;
			scl_q <= 1'b1; drv_q <= 1'b1; lvl_q <= 1'b1;
			m_tvalid <= 1'b0; m_tdata <= '0;
		end else begin
			ph_q <= ph_n; sg_q <= sg_n; dly_q <= dly_n; awc_q <= awc_n; bit_q <= bit_n;
			sh_q <= sh_n; rem_q <= rem_n; dev_q <= dev_n; adr_q <= adr_n; flg_q <= flg_n;
			hh_q <= hh_n; wa_q <= wa_n; ack_q <= ack_n; fill_q <= fill_n;
			scl_q <= scl_n; drv_q <= drv_n; lvl_q <= lvl_n;
			if (adv) begin
				m_tvalid <= 1'b1;
				m_tdata <= {7'd0, pd, (ph_n == PH_WAIT), ack_n, pl, pdat, pv,
					(ph_n != PH_IDLE), lvl_n & drv_n, drv_n, scl_n};
			end else if (m_tready) m_tvalid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FifoDepth[FillW-1:0]) else $error("fifo fill over depth");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_IDLE) |-> (scl_q && drv_q && lvl_q)) else $error("idle bus not released");
	a_bits: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd8) else $error("bit index over range");
`endif

endmodule
